// ----- rtl/assert_macros.svh -----
// assertion macros used by the thermometer display serialiser
// expects i_clk and i_rst_n (synchronous, active low) in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every edge outside reset
`define TSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// antecedent this edge, consequent at the next edge
`define TSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tssd_pkg.sv -----
`timescale 1ns / 1ps
// types, constants and segment table for the thermometer display driver
// no dependencies
package tssd_pkg;

    localparam int unsigned ADC_W   = 10;
    localparam int unsigned CFG_W   = 10;
    localparam int unsigned CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING_TENTHS = 1'b1;

    localparam logic [CFG_W-1:0] ZERO_OFFSET_RST    = 10'd500;
    localparam logic [CFG_W-1:0] CEILING_TENTHS_RST = 10'd377;

    // reciprocal multipliers for divide by ten
    localparam int unsigned RECIP10_16 = 6554;  // exact for values below 4096
    localparam int unsigned RECIP10_11 = 205;   // exact for values below 1024

    localparam logic [11:0] FAHR_OFFSET = 12'd320;

    localparam logic [7:0] SEG_DP = 8'h80;
    localparam logic [7:0] SYM_C  = 8'h39;
    localparam logic [7:0] SYM_F  = 8'h71;

    // display positions
    localparam logic [1:0] POS_HUND = 2'd0;
    localparam logic [1:0] POS_TENS = 2'd1;
    localparam logic [1:0] POS_ONES = 2'd2;
    localparam logic [1:0] POS_SYM  = 2'd3;

    typedef struct packed {
        logic [ADC_W-1:0] adc_value;
        logic             show_fahrenheit;
    } t_in_word;

    typedef struct packed {
        logic [7:0] segments;
        logic [1:0] digit_position;
        logic       blank;
        logic       last;
    } t_out_word;

    // clamped celsius tenths and its tenth
    typedef struct packed {
        logic [9:0] tenths;
        logic [6:0] degrees;
        logic       fahr;
    } t_temp_word;

    typedef struct packed {
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
        logic       fahr;
    } t_digit_word;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h67;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ----- rtl/tssd_temp.sv -----
`timescale 1ns / 1ps
// input register and offset / clamp stage, celsius tenths and whole degrees
// depends on tssd_pkg
module tssd_temp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [9:0]             i_zero_offset,
    input  logic [9:0]             i_ceiling_tenths,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  tssd_pkg::t_in_word     i_word,
    output logic                   o_valid,
    input  logic                   i_ready,
    output tssd_pkg::t_temp_word   o_word
);
    import tssd_pkg::*;

    logic       r_s1_valid;
    t_in_word   r_s1_word;
    logic       r_s2_valid;
    t_temp_word r_s2_word;

    logic        w_rdy1;
    logic        w_rdy2;
    logic [9:0]  w_diff;
    logic [9:0]  w_tenths;
    logic [22:0] w_prod;
    t_temp_word  n_s2_word;

    assign w_rdy2  = !r_s2_valid || i_ready;
    assign w_rdy1  = !r_s1_valid || w_rdy2;
    assign o_ready = w_rdy1;

    // subtract offset, floor at zero, then clamp to ceiling
    always_comb begin
        w_diff = (r_s1_word.adc_value < i_zero_offset) ? 10'd0
                                                        : r_s1_word.adc_value - i_zero_offset;
        w_tenths = (w_diff > i_ceiling_tenths) ? i_ceiling_tenths : w_diff;
        w_prod   = 23'(w_tenths) * 23'(RECIP10_16);
        n_s2_word.tenths  = w_tenths;
        n_s2_word.degrees = w_prod[22:16];
        n_s2_word.fahr    = r_s1_word.show_fahrenheit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_rdy1) r_s1_valid <= i_valid;
            if (w_rdy2) r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) r_s1_word <= i_word;
        if (w_rdy2 && r_s1_valid) r_s2_word <= n_s2_word;
    end

    assign o_valid = r_s2_valid;
    assign o_word  = r_s2_word;

endmodule

// ----- rtl/tssd_digits.sv -----
`timescale 1ns / 1ps
// unit conversion and decimal digit split over two stages
// depends on tssd_pkg
module tssd_digits (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  tssd_pkg::t_temp_word   i_word,
    output logic                   o_valid,
    input  logic                   i_ready,
    output tssd_pkg::t_digit_word  o_word
);
    import tssd_pkg::*;

    logic        r_s3_valid;
    logic [7:0]  r_s3_q1;
    logic [3:0]  r_s3_ones;
    logic        r_s3_fahr;
    logic        r_s4_valid;
    t_digit_word r_s4_word;

    logic        w_rdy3;
    logic        w_rdy4;
    logic [11:0] w_value;
    logic [24:0] w_prod1;
    logic [7:0]  w_q1;
    logic [11:0] w_q1x10;
    logic [11:0] w_rem1;
    logic [15:0] w_prod2;
    logic [4:0]  w_q2;
    logic [7:0]  w_q2x10;
    logic [7:0]  w_rem2;
    logic [4:0]  w_hund;
    t_digit_word n_s4_word;

    assign w_rdy4  = !r_s4_valid || i_ready;
    assign w_rdy3  = !r_s3_valid || w_rdy4;
    assign o_ready = w_rdy3;

    // display value, then value / 10 and the ones digit
    always_comb begin
        w_value = i_word.fahr
                  ? (12'(i_word.degrees) << 4) + (12'(i_word.degrees) << 1) + FAHR_OFFSET
                  : 12'(i_word.tenths);
        w_prod1 = 25'(w_value) * 25'(RECIP10_16);
        w_q1    = w_prod1[23:16];
        w_q1x10 = (12'(w_q1) << 3) + (12'(w_q1) << 1);
        w_rem1  = w_value - w_q1x10;
    end

    // tens digit and hundreds modulo ten
    always_comb begin
        w_prod2 = 16'(r_s3_q1) * 16'(RECIP10_11);
        w_q2    = w_prod2[15:11];
        w_q2x10 = (8'(w_q2) << 3) + (8'(w_q2) << 1);
        w_rem2  = r_s3_q1 - w_q2x10;
        if (w_q2 >= 5'd20)      w_hund = w_q2 - 5'd20;
        else if (w_q2 >= 5'd10) w_hund = w_q2 - 5'd10;
        else                    w_hund = w_q2;
        n_s4_word.hund = w_hund[3:0];
        n_s4_word.tens = w_rem2[3:0];
        n_s4_word.ones = r_s3_ones;
        n_s4_word.fahr = r_s3_fahr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (w_rdy3) r_s3_valid <= i_valid;
            if (w_rdy4) r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && i_valid) begin
            r_s3_q1   <= w_q1;
            r_s3_ones <= w_rem1[3:0];
            r_s3_fahr <= i_word.fahr;
        end
        if (w_rdy4 && r_s3_valid) r_s4_word <= n_s4_word;
    end

    assign o_valid = r_s4_valid;
    assign o_word  = r_s4_word;

endmodule

// ----- rtl/tssd_serial.sv -----
`timescale 1ns / 1ps
// holds one sample's digits and sends its four segment words in turn
// depends on tssd_pkg and assert_macros.svh
`include "assert_macros.svh"
module tssd_serial (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  tssd_pkg::t_digit_word  i_word,
    output logic                   o_valid,
    input  logic                   i_ready,
    output tssd_pkg::t_out_word    o_word
);
    import tssd_pkg::*;

    localparam logic [1:0] IDX_SYM  = 2'd0;
    localparam logic [1:0] IDX_ONES = 2'd3;

    logic        r_busy;
    logic [1:0]  r_idx;
    t_digit_word r_dig;
    t_out_word   r_word;

    logic        w_load;
    logic        w_step;
    t_out_word   n_word;

    function automatic t_out_word word_for(input logic [1:0] idx, input t_digit_word dig);
        t_out_word w;
        w = '0;
        case (idx)
            2'd0: begin
                w.segments       = dig.fahr ? SYM_F : SYM_C;
                w.digit_position = POS_SYM;
            end
            2'd1: begin
                // leading zero hundreds stays dark
                w.blank          = (dig.hund == 4'd0);
                w.segments       = w.blank ? 8'h00 : seg_of(dig.hund);
                w.digit_position = POS_HUND;
            end
            2'd2: begin
                w.segments       = seg_of(dig.tens) | SEG_DP;
                w.digit_position = POS_TENS;
            end
            default: begin
                w.segments       = seg_of(dig.ones);
                w.digit_position = POS_ONES;
                w.last           = 1'b1;
            end
        endcase
        return w;
    endfunction

    assign o_ready = !r_busy || (i_ready && r_idx == IDX_ONES);
    assign w_load  = i_valid && o_ready;
    assign w_step  = r_busy && i_ready && r_idx != IDX_ONES;
    assign n_word  = word_for(r_idx + 2'd1, r_dig);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= IDX_SYM;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_idx  <= IDX_SYM;
        end else if (r_busy && i_ready) begin
            if (r_idx == IDX_ONES) r_busy <= 1'b0;
            else                   r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_dig  <= i_word;
            r_word <= word_for(IDX_SYM, i_word);
        end else if (w_step) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_busy;
    assign o_word  = r_word;

    `TSD_ASSERT(a_last_is_ones, (o_valid && o_word.last) |-> (o_word.digit_position == POS_ONES), "last word not at ones position")
    `TSD_ASSERT_NEXT(a_symbol_first, o_valid && i_ready && o_word.last, !o_valid || o_word.digit_position == POS_SYM, "sample did not open with symbol")
    `TSD_ASSERT(a_no_take_mid, (r_busy && r_idx != IDX_ONES) |-> !o_ready, "new sample taken mid sequence")
    `TSD_ASSERT(a_blank_dark, (o_valid && o_word.blank) |-> (o_word.segments == 8'h00), "blank digit has segments lit")

endmodule

// ----- rtl/thermometer_seven_segment_driver_core.sv -----
`timescale 1ns / 1ps
// top level of the seven segment thermometer driver
// depends on tssd_pkg, tssd_temp, tssd_digits, tssd_serial
//
// usage
//   input channel: i_in_valid / o_in_ready carry one word per sample, a ten
//   bit converter reading plus the unit select (1 fahrenheit, 0 celsius)
//   output channel: o_out_valid / i_out_ready carry four segment words per
//   sample, in order unit symbol, hundreds, tens (with decimal point), ones;
//   last marks the ones word, blank marks a dark leading zero hundreds
//   config port: i_cfg_we writes i_cfg_wdata into register i_cfg_idx at the
//   clock edge, 0 zero offset, 1 ceiling in tenths; write only while idle
// timing
//   four register stages (input, clamp, convert, digit split) feed the word
//   serialiser, whose output register takes the symbol word from the digit
//   split stage; the serialiser sends one word a cycle while the receiver is
//   ready and takes a new sample only as the ones word of the last is taken
//   up to four samples sit in the stages while the output is busy
// reset and stall
//   synchronous active low reset empties every stage and reloads the offset
//   with 500 and the ceiling with 377
//   a stalled receiver holds the current word; the stages fill behind it
//   and o_in_ready drops once all are full
module thermometer_seven_segment_driver_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  tssd_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output tssd_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_we,
    input  logic [tssd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tssd_pkg::CFG_W-1:0]          i_cfg_wdata
);
    import tssd_pkg::*;

    logic [CFG_W-1:0] r_zero_offset;
    logic [CFG_W-1:0] r_ceiling_tenths;

    logic        w_temp_valid;
    logic        w_temp_ready;
    t_temp_word  w_temp_word;
    logic        w_dig_valid;
    logic        w_dig_ready;
    t_digit_word w_dig_word;

    // configuration registers, plain write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset    <= ZERO_OFFSET_RST;
            r_ceiling_tenths <= CEILING_TENTHS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ZERO_OFFSET:    r_zero_offset    <= i_cfg_wdata;
                CFG_CEILING_TENTHS: r_ceiling_tenths <= i_cfg_wdata;
                default:            ;
            endcase
        end
    end

    // offset removal and clamp
    tssd_temp u_temp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_zero_offset    (r_zero_offset),
        .i_ceiling_tenths (r_ceiling_tenths),
        .i_valid          (i_in_valid),
        .o_ready          (o_in_ready),
        .i_word           (i_in_word),
        .o_valid          (w_temp_valid),
        .i_ready          (w_temp_ready),
        .o_word           (w_temp_word)
    );

    // unit conversion and digit split
    tssd_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_temp_valid),
        .o_ready (w_temp_ready),
        .i_word  (w_temp_word),
        .o_valid (w_dig_valid),
        .i_ready (w_dig_ready),
        .o_word  (w_dig_word)
    );

    // four words per sample onto the output channel
    tssd_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dig_valid),
        .o_ready (w_dig_ready),
        .i_word  (w_dig_word),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule
